// ===== design/pcrs_pkg.sv =====
package pcrs_pkg;

   localparam int COUNT_WIDTH = 16;
   localparam int CFG_WIDTH   = 16;
   localparam int CSR_INDEX_WIDTH = 2;

   localparam logic [32:0] COUNT_MAX_WIDE = (33'd1 << COUNT_WIDTH) - 33'd1;

   typedef logic [COUNT_WIDTH-1:0] count_type;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_CUT    = 3'd1,
      PH_WAIT1  = 3'd2,
      PH_BUTTON = 3'd3,
      PH_WAIT2  = 3'd4
   } phase_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_CUT_PULSE    = 2'd0,
      CSR_BUTTON_PULSE = 2'd1,
      CSR_WAIT_POWER   = 2'd2
   } csr_index_type;

   localparam logic OP_TICK  = 1'b0;
   localparam logic OP_START = 1'b1;

   typedef struct packed {
      logic op;
      logic power_sense_n;
   } req_type;

   typedef struct packed {
      logic       cut_power;
      logic       press_button;
      logic       busy_res;
      logic       done_res;
      logic [2:0] phase;
   } rsp_type;

   typedef struct packed {
      logic [CFG_WIDTH-1:0] cut_pulse_ticks;
      logic [CFG_WIDTH-1:0] button_pulse_ticks;
      logic [CFG_WIDTH-1:0] wait_power_ticks;
   } cfg_type;

   // clamp a register value to the countdown range
   function automatic count_type load_value(input logic [CFG_WIDTH-1:0] v);
      logic [32:0] wide;
      wide = 33'(v);
      if (wide > COUNT_MAX_WIDE) begin
         return COUNT_WIDTH'(COUNT_MAX_WIDE);
      end
      return COUNT_WIDTH'(wide);
   endfunction

endpackage

// ===== design/pcrs_csr.sv =====
module pcrs_csr
   import pcrs_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CFG_WIDTH-1:0]       csr_data,
   output cfg_type                    cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_CUT_PULSE:    cfg_in.cut_pulse_ticks    = csr_data;
            CSR_BUTTON_PULSE: cfg_in.button_pulse_ticks = csr_data;
            CSR_WAIT_POWER:   cfg_in.wait_power_ticks   = csr_data;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cut_pulse_ticks    <= CFG_WIDTH'(1000);
         cfg_ff.button_pulse_ticks <= CFG_WIDTH'(500);
         cfg_ff.wait_power_ticks   <= CFG_WIDTH'(5000);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== design/pcrs_core.sv =====
module pcrs_core
   import pcrs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    accept,
   input  req_type req,
   input  cfg_type cfg,
   output rsp_type rsp
);

   phase_type phase_ff;
   phase_type phase_in;
   count_type count_ff;
   count_type count_in;
   logic      cut_ff;
   logic      cut_in;
   logic      button_ff;
   logic      button_in;
   logic      done;
   count_type count_dec;

   assign count_dec = (count_ff == '0) ? count_ff : count_ff - COUNT_WIDTH'(1);

   // next state
   always_comb begin
      phase_in  = phase_ff;
      count_in  = count_ff;
      cut_in    = cut_ff;
      button_in = button_ff;
      done      = 1'b0;
      if (req.op == OP_START) begin
         if (phase_ff == PH_IDLE) begin
            cut_in   = 1'b1;
            count_in = load_value(cfg.cut_pulse_ticks);
            phase_in = PH_CUT;
         end
      end else begin
         unique case (phase_ff)
            PH_IDLE: begin
            end
            PH_CUT, PH_BUTTON: begin
               count_in = count_dec;
               if (count_dec <= COUNT_WIDTH'(1)) begin
                  if (phase_ff == PH_CUT) begin
                     cut_in   = 1'b0;
                     phase_in = PH_WAIT1;
                  end else begin
                     button_in = 1'b0;
                     phase_in  = PH_WAIT2;
                  end
                  count_in = load_value(cfg.wait_power_ticks);
               end
            end
            PH_WAIT1, PH_WAIT2: begin
               if (count_ff > COUNT_WIDTH'(1) && !req.power_sense_n) begin
                  phase_in = PH_IDLE;
                  count_in = '0;
                  done     = 1'b1;
               end else begin
                  count_in = count_dec;
                  if (count_dec <= COUNT_WIDTH'(1)) begin
                     if (phase_ff == PH_WAIT1) begin
                        button_in = 1'b1;
                        count_in  = load_value(cfg.button_pulse_ticks);
                        phase_in  = PH_BUTTON;
                     end else begin
                        cut_in   = 1'b1;
                        count_in = load_value(cfg.cut_pulse_ticks);
                        phase_in = PH_CUT;
                     end
                  end
               end
            end
            default: begin
               phase_in  = PH_IDLE;
               count_in  = '0;
               cut_in    = 1'b0;
               button_in = 1'b0;
            end
         endcase
      end
   end

   // result
   always_comb begin
      rsp.cut_power    = cut_in;
      rsp.press_button = button_in;
      rsp.busy_res     = (phase_in != PH_IDLE);
      rsp.done_res     = done;
      rsp.phase        = phase_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         count_ff  <= '0;
         cut_ff    <= 1'b0;
         button_ff <= 1'b0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         count_ff  <= count_in;
         cut_ff    <= cut_in;
         button_ff <= button_in;
      end
   end

   a_levels_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(cut_ff && button_ff))
      else $error("cut and button asserted together");

   a_idle_released: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_IDLE) |-> (!cut_ff && !button_ff))
      else $error("output held while idle");

   a_start_enters_cut: assert property (@(posedge clock) disable iff (reset)
      (accept && req.op == OP_START && phase_ff == PH_IDLE)
      |=> (phase_ff == PH_CUT && cut_ff))
      else $error("start did not enter cut phase");

   a_done_goes_idle: assert property (@(posedge clock) disable iff (reset)
      (accept && done) |=> (phase_ff == PH_IDLE && count_ff == '0))
      else $error("done without returning idle");

endmodule

// ===== design/pcrs_out_skid.sv =====
module pcrs_out_skid
   import pcrs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_stall,
   input  rsp_type in_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic    out_valid_ff;
   logic    out_valid_in;
   rsp_type out_data_ff;
   rsp_type out_data_in;
   logic    skid_valid_ff;
   logic    skid_valid_in;
   rsp_type skid_data_ff;
   rsp_type skid_data_in;
   logic    out_free;

   assign in_stall  = skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;
   assign out_free  = !out_valid_ff || !rsp_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_free) begin
         out_valid_in  = skid_valid_ff || in_valid;
         out_data_in   = skid_valid_ff ? skid_data_ff : in_data;
         skid_valid_in = 1'b0;
      end else if (in_valid) begin
         skid_valid_in = 1'b1;
         skid_data_in  = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid holds a transaction while output is empty");

   a_no_accept_when_full: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> !in_valid)
      else $error("transaction pushed into full buffer");

endmodule

// ===== design/power_cycle_reboot_sequencer.sv =====
// power cycle reboot sequencer
//
// req channel: one transaction per event, op 0 is a time tick, op 1 starts
// a reboot sequence; power_sense_n is the host power pin (low = power on)
// rsp channel: one transaction per accepted req, showing the cut and button
// output levels, busy, done and the phase after that event
// csr channel: writes cut_pulse_ticks (0), button_pulse_ticks (1) and
// wait_power_ticks (2); csr_ready is always high, index 3 is dropped
//
// response: registered in the output register, or the skid entry if stalled
// throughput: one transaction per cycle while req_stall is low, set by the
// single state update between the sequencer and response registers
// stall: a two-entry response buffer absorbs one extra transaction; once
// both entries hold data req_stall rises until rsp_stall drops
// reset: the sequencer returns to idle with both outputs released, the
// buffer empties and the timing registers reload 1000, 500 and 5000
module power_cycle_reboot_sequencer
   import pcrs_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  req_type                    req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output rsp_type                    rsp_data,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CFG_WIDTH-1:0]       csr_data
);

   cfg_type cfg;
   rsp_type core_rsp;
   logic    accept;

   assign accept = req_valid && !req_stall;

   pcrs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   pcrs_core u_core (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_data),
      .cfg    (cfg),
      .rsp    (core_rsp)
   );

   pcrs_out_skid u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_stall  (req_stall),
      .in_data   (core_rsp),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
